FILE: hw/rtl/deq_pkg.sv
// Package for the double-ended queue unit: sizes, ring index types, action and status codes.
// No dependencies.
package deq_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int ACTION_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int OCC_W      = 5;
   localparam int STATUS_W   = 2;

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [CNT_W-1:0]      count_type;

   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_PEEK       = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   // (base + offset) mod CAPACITY, offset <= CAPACITY
   function automatic addr_type ring_add(input addr_type base, input count_type offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
      if (sum >= (CNT_W + 1)'(CAPACITY)) begin
         sum = sum - (CNT_W + 1)'(CAPACITY);
      end
      return ADDR_W'(sum);
   endfunction

endpackage

FILE: hw/rtl/deq_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module deq_ram #(
   parameter int  DEPTH = 16,
   parameter int  WIDTH = 32,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: hw/rtl/double_ended_queue_unit.sv
// Double-ended queue unit: ring buffer of words in a synchronous RAM.
// Uses deq_pkg and deq_ram.
// Each accepted item passes the RAM read (ST_READ) and then the output load (ST_LOAD);
// the load waits while a stalled result holds the output register. Requests stall until the load.
// The next item is taken while a result waits in the output register.
// Reset (synchronous): queue empty, head at slot 0, no result pending; RAM not cleared.
module double_ended_queue_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [deq_pkg::ACTION_W-1:0]    req_action,
   input  logic [deq_pkg::VALUE_W-1:0]     req_item_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [deq_pkg::VALUE_W-1:0]     rsp_front_value,
   output logic [deq_pkg::VALUE_W-1:0]     rsp_back_value,
   output logic                            rsp_is_empty,
   output logic                            rsp_is_full,
   output logic [deq_pkg::OCC_W-1:0]       rsp_occupancy,
   output logic [deq_pkg::STATUS_W-1:0]    rsp_status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type                        state_ff;
   deq_pkg::addr_type                head_ff,  head_in;
   deq_pkg::count_type               count_ff, count_in;
   logic [deq_pkg::STATUS_W-1:0]     status_ff, status_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::VALUE_W-1:0]      rsp_front_ff;
   logic [deq_pkg::VALUE_W-1:0]      rsp_back_ff;
   logic                             rsp_empty_ff;
   logic                             rsp_full_ff;
   logic [deq_pkg::OCC_W-1:0]        rsp_occ_ff;
   logic [deq_pkg::STATUS_W-1:0]     rsp_status_ff;

   logic                             accept;
   logic                             push_ok;
   logic                             pop_ok;
   logic                             wr_en;
   deq_pkg::addr_type                wr_addr;
   deq_pkg::addr_type                rd_addr_front;
   deq_pkg::addr_type                rd_addr_back;
   deq_pkg::data_type                rd_front;
   deq_pkg::data_type                rd_back;
   logic                             out_free;
   logic                             load_rsp;
   logic                             is_empty_now;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign push_ok   = (count_ff != deq_pkg::CNT_W'(deq_pkg::CAPACITY));
   assign pop_ok    = (count_ff != '0);

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = deq_pkg::STATUS_OK;
      wr_en     = 1'b0;
      wr_addr   = deq_pkg::ring_add(head_ff, count_ff);
      unique case (req_action)
         deq_pkg::ACT_PUSH_BACK: begin
            if (push_ok) begin
               wr_en    = accept;
               count_in = count_ff + 1'b1;
            end else begin
               status_in = deq_pkg::STATUS_OVERFLOW;
            end
         end
         deq_pkg::ACT_PUSH_FRONT: begin
            if (push_ok) begin
               head_in  = deq_pkg::ring_add(head_ff,
                                            deq_pkg::CNT_W'(deq_pkg::CAPACITY - 1));
               wr_addr  = head_in;
               wr_en    = accept;
               count_in = count_ff + 1'b1;
            end else begin
               status_in = deq_pkg::STATUS_OVERFLOW;
            end
         end
         deq_pkg::ACT_POP_BACK: begin
            if (pop_ok) begin
               count_in = count_ff - 1'b1;
            end else begin
               status_in = deq_pkg::STATUS_UNDERFLOW;
            end
         end
         deq_pkg::ACT_POP_FRONT: begin
            if (pop_ok) begin
               head_in  = deq_pkg::ring_add(head_ff, deq_pkg::CNT_W'(1));
               count_in = count_ff - 1'b1;
            end else begin
               status_in = deq_pkg::STATUS_UNDERFLOW;
            end
         end
         default: begin
            // peek and unused codes
         end
      endcase
   end

   assign rd_addr_front = head_ff;
   assign rd_addr_back  = pop_ok ? deq_pkg::ring_add(head_ff, count_ff - 1'b1) : head_ff;

   deq_ram #(
      .DEPTH (deq_pkg::CAPACITY),
      .WIDTH (deq_pkg::DATA_WIDTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (deq_pkg::data_type'(req_item_value)),
      .rd_en     (state_ff == ST_READ),
      .rd_addr_a (rd_addr_front),
      .rd_addr_b (rd_addr_back),
      .rd_data_a (rd_front),
      .rd_data_b (rd_back)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign load_rsp     = (state_ff == ST_LOAD) && out_free;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   assign is_empty_now = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  head_ff   <= head_in;
                  count_ff  <= count_in;
                  status_ff <= status_in;
                  state_ff  <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               if (load_rsp) begin
                  rsp_front_ff  <= is_empty_now ? '0 : deq_pkg::VALUE_W'(rd_front);
                  rsp_back_ff   <= is_empty_now ? '0 : deq_pkg::VALUE_W'(rd_back);
                  rsp_empty_ff  <= is_empty_now;
                  rsp_full_ff   <= !push_ok;
                  rsp_occ_ff    <= deq_pkg::OCC_W'(count_ff);
                  rsp_status_ff <= status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;
   assign rsp_occupancy   = rsp_occ_ff;
   assign rsp_status      = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= deq_pkg::CNT_W'(deq_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && status_in != deq_pkg::STATUS_OK) |=> $stable(count_ff) && $stable(head_ff))
      else $error("refused item changed queue state");

   a_empty_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_front_ff == '0 && rsp_back_ff == '0
                                         && rsp_occ_ff == '0))
      else $error("empty result with nonzero payload");

   a_no_overwrite_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_front_ff)
                                      && $stable(rsp_status_ff))
      else $error("pending result overwritten");

endmodule
